// ----- rtl/echs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package echs_pkg;
	localparam int TableDepthDefault = 1024;
	localparam logic [63:0] FnvOffset = 64'd1469598103934665603;
	localparam logic [63:0] FnvPrime = 64'd1099511628211;
	localparam logic [63:0] MixMult = 64'hd6e8feb86659fd93;
	localparam logic [4:0] MinLog2 = 5'd4;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_COMMIT = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] key_top;
		logic [63:0] key_middle;
		logic [63:0] key_bottom;
		logic mark_originally_delegated;
		logic mark_delegation_set;
		logic [15:0] expected_count;
	} item_t;

	typedef struct packed {
		logic was_seen;
		logic is_originally_delegated;
		logic has_delegation_set;
		logic table_full;
	} result_t;

	typedef struct packed {
		logic start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;
endpackage
`default_nettype wire

// ----- rtl/epoch_cleared_hash_set_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                        Handshake
// item      start, busy, item            accepted when start && !busy
// result    result_valid, result         one-cycle strobe, cannot be stalled
//
// A lookup or commit runs 21 multiplies (20 FNV rounds and one mix) on the
// shared multiplier, then reads and compares one probed slot after another,
// with busy high throughout. A clear grows the capacity one doubling at a time
// until it covers the need or reaches its maximum, then raises result_valid.
// After reset, and after an epoch wrap, a clearing pass zeroes every slot
// epoch while busy stays high.
module epoch_cleared_hash_set_top #(
	parameter int TABLE_DEPTH = echs_pkg::TableDepthDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire echs_pkg::item_t item,
	output logic busy,
	output logic result_valid,
	output echs_pkg::result_t result
);
	import echs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	// Log2 of the largest power of two not above the table depth.
	localparam logic [4:0] MaxLog2 = 5'($clog2(TABLE_DEPTH + 1) - 1);
	localparam int SW = AW + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_WIPE = 4'd1;
	localparam logic [3:0] ST_FNV = 4'd2;
	localparam logic [3:0] ST_FNVW = 4'd3;
	localparam logic [3:0] ST_MIX = 4'd4;
	localparam logic [3:0] ST_MIXW = 4'd5;
	localparam logic [3:0] ST_RD = 4'd6;
	localparam logic [3:0] ST_CMP = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;
	localparam logic [3:0] ST_CAP = 4'd9;

	logic [3:0] state_q;
	item_t item_q;
	logic [31:0] epoch_q;
	logic [4:0] cap_log2_q;
	logic [4:0] byte_q;
	logic [63:0] h_q;
	logic [AW-1:0] slot_q, wipe_q, mask;
	logic [SW-1:0] probes_q;
	logic [159:0] key_bits;
	logic [7:0] cur_byte;
	mul_req_t mreq;
	logic [63:0] prod;
	logic mdone;
	logic [16:0] need_q;

	logic [31:0] epoch_mem [TABLE_DEPTH];
	logic [159:0] key_mem [TABLE_DEPTH];
	logic [1:0] flag_mem [TABLE_DEPTH];
	logic [31:0] rd_epoch;
	logic [159:0] rd_key;
	logic [1:0] rd_flag;
	logic ep_we, ent_we;
	logic [AW-1:0] ep_addr;
	logic [31:0] ep_wdata;
	logic [1:0] new_flag;
	logic [63:0] mixed;

	echs_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .prod(prod), .done(mdone));

	assign key_bits = {item_q.key_top, item_q.key_middle, item_q.key_bottom};
	assign cur_byte = key_bits[8'(159 - 8 * byte_q) -: 8];
	assign mask = AW'((({{(SW-1){1'b0}}, 1'b1} << cap_log2_q)) - 1'b1);
	assign mixed = h_q ^ {32'd0, h_q[63:32]};

	always_comb begin
		mreq.start = 1'b0;
		mreq.a = h_q ^ {56'd0, cur_byte};
		mreq.b = FnvPrime;
		if (state_q == ST_FNV) begin
			mreq.start = 1'b1;
		end else if (state_q == ST_MIX) begin
			mreq.start = 1'b1;
			mreq.a = mixed;
			mreq.b = MixMult;
		end
	end

	wire live = (rd_epoch == epoch_q);
	wire hit = live && (rd_key == key_bits);
	wire full_now = live && !hit && (probes_q == SW'(({{(SW-1){1'b0}}, 1'b1} << cap_log2_q) - 1));
	assign new_flag = (hit ? rd_flag : 2'b00) |
		{item_q.mark_originally_delegated, item_q.mark_delegation_set};

	always_comb begin
		ep_we = 1'b0;
		ent_we = 1'b0;
		ep_addr = slot_q;
		ep_wdata = epoch_q;
		if (state_q == ST_WIPE) begin
			ep_we = 1'b1;
			ep_addr = wipe_q;
			ep_wdata = 32'd0;
		end else if (state_q == ST_CMP && item_q.action == ACT_COMMIT && !full_now &&
			(hit || !live)) begin
			ent_we = 1'b1;
			ep_we = !live;
		end
	end

	always_ff @(posedge clk) begin
		if (ep_we) epoch_mem[ep_addr] <= ep_wdata;
		if (ent_we) begin
			flag_mem[slot_q] <= new_flag;
			if (!live) key_mem[slot_q] <= key_bits;
		end
		rd_epoch <= epoch_mem[slot_q];
		rd_key <= key_mem[slot_q];
		rd_flag <= flag_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
			wipe_q <= '0;
			slot_q <= '0;
			epoch_q <= 32'd1;
			cap_log2_q <= MinLog2;
			result_valid <= 1'b0;
			result <= '0;
			byte_q <= '0;
			probes_q <= '0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						byte_q <= '0;
						probes_q <= '0;
						if (item.action == ACT_CLEAR) begin
							// Capacity is recomputed from the minimum on every clear.
							cap_log2_q <= MinLog2;
							state_q <= ST_CAP;
						end else if (item.action == ACT_LOOKUP || item.action == ACT_COMMIT)
							state_q <= ST_FNV;
						else begin
							result <= '0;
							result_valid <= 1'b1;
						end
					end
				end
				ST_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
					if (wipe_q == AW'(TABLE_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_CAP: begin
					// Grow one doubling per cycle until capacity covers the need or reaches the maximum.
					if (cap_log2_q < MaxLog2 && (17'd1 << cap_log2_q) < need_q) begin
						cap_log2_q <= cap_log2_q + 5'd1;
					end else begin
						result <= '0;
						result_valid <= 1'b1;
						if (epoch_q == 32'hffff_ffff) begin
							epoch_q <= 32'd1;
							wipe_q <= '0;
							state_q <= ST_WIPE;
						end else begin
							epoch_q <= epoch_q + 32'd1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FNV: state_q <= ST_FNVW;
				ST_FNVW: if (mdone) begin
					byte_q <= byte_q + 5'd1;
					state_q <= (byte_q == 5'd19) ? ST_MIX : ST_FNV;
				end
				ST_MIX: state_q <= ST_MIXW;
				ST_MIXW: if (mdone) begin
					slot_q <= AW'(prod ^ {32'd0, prod[63:32]}) & mask;
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_OUT;
				ST_OUT: state_q <= ST_CMP;
				ST_CMP: begin
					if (hit || !live || full_now) begin
						result.was_seen <= hit;
						result.table_full <= full_now;
						result.is_originally_delegated <= full_now ? 1'b0 :
							(hit ? (item_q.action == ACT_COMMIT ? new_flag[1] : rd_flag[1]) :
							(item_q.action == ACT_COMMIT && item_q.mark_originally_delegated));
						result.has_delegation_set <= full_now ? 1'b0 :
							(hit ? (item_q.action == ACT_COMMIT ? new_flag[0] : rd_flag[0]) :
							(item_q.action == ACT_COMMIT && item_q.mark_delegation_set));
						result_valid <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						slot_q <= (slot_q + 1'b1) & mask;
						probes_q <= probes_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Mixing start slot is captured into slot_q; hash registers follow the multiplier.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
			h_q <= FnvOffset;
			need_q <= {item.expected_count, 1'b0};
		end else if (state_q == ST_FNVW && mdone) begin
			h_q <= prod;
		end
	end

	assign busy = (state_q != ST_IDLE);

	ap_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= 5'd20) else $error("byte counter range");
	ap_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.table_full |-> !result.was_seen) else $error("full and seen");
	ap_epoch_nz: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != 32'd0) else $error("zero epoch");
	ap_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cap_log2_q >= MinLog2 && cap_log2_q <= MaxLog2) else $error("capacity range");
endmodule
`default_nettype wire

// ----- rtl/echs_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// 64x64 low-half multiplier built from three 32x32 partial products,
// one partial product per cycle. The product is valid while done is high.
module echs_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire echs_pkg::mul_req_t req,
	output logic [63:0] prod,
	output logic done
);
	import echs_pkg::*;

	logic [1:0] step_q;
	logic busy_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [31:0] x, y;
	logic [63:0] pp;

	always_comb begin
		x = step_q[0] ? a_q[63:32] : a_q[31:0];
		y = step_q[1] ? b_q[63:32] : b_q[31:0];
	end
	assign pp = {32'd0, x} * {32'd0, y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				// Step 3 (high times high) only affects bits above 63 and is skipped.
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= 64'd0;
		end else if (busy_q) begin
			case (step_q)
				2'd0: acc_q <= acc_q + pp;
				2'd1: acc_q <= acc_q + {pp[31:0], 32'd0};
				2'd2: acc_q <= acc_q + {pp[31:0], 32'd0};
				default: acc_q <= acc_q;
			endcase
		end
	end
	assign prod = acc_q;
endmodule
`default_nettype wire

// ----- dv/epoch_cleared_hash_set_top_tb.sv -----
`timescale 1ns / 1ps
module epoch_cleared_hash_set_top_tb;
	import echs_pkg::*;

	localparam int Depth = 1024;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	item_t item;
	logic busy;
	logic result_valid;
	result_t result;

	epoch_cleared_hash_set_top #(.TABLE_DEPTH(Depth)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	// Shadow copy of the table used to work out the expected flags.
	logic [31:0] shadow_epoch_now;
	logic [4:0] shadow_cap_log2;
	logic [31:0] shadow_slot_epoch [Depth];
	logic [31:0] shadow_key_top [Depth];
	logic [63:0] shadow_key_middle [Depth];
	logic [63:0] shadow_key_bottom [Depth];
	logic shadow_orig [Depth];
	logic shadow_set [Depth];

	item_t pending_items[$];
	result_t expected_results[$];
	int error_count;
	bit stimulus_done;
	int gap_left;
	int burst_left;

	// Keys drawn from a small pool so commits and lookups hit each other.
	logic [159:0] key_pool [32];

	function automatic logic [63:0] key_hash(logic [31:0] kt, logic [63:0] km,
			logic [63:0] kb);
		logic [159:0] bytes;
		logic [63:0] h;
		bytes = {kt, km, kb};
		h = FnvOffset;
		for (int i = 19; i >= 0; i--) begin
			h = h ^ {56'd0, bytes[i*8 +: 8]};
			h = h * FnvPrime;
		end
		h = h ^ (h >> 32);
		h = h * MixMult;
		h = h ^ (h >> 32);
		return h;
	endfunction

	task automatic shadow_reset();
		shadow_epoch_now = 32'd1;
		shadow_cap_log2 = MinLog2;
		for (int i = 0; i < Depth; i++) begin
			shadow_slot_epoch[i] = '0;
			shadow_key_top[i] = '0;
			shadow_key_middle[i] = '0;
			shadow_key_bottom[i] = '0;
			shadow_orig[i] = 1'b0;
			shadow_set[i] = 1'b0;
		end
	endtask

	function automatic result_t predict_membership(item_t it);
		result_t r;
		int cap;
		int lg;
		int need;
		int slot;
		int mask;
		bit found;
		bit free_slot;
		r = '0;
		found = 0;
		free_slot = 0;
		if (it.action == ACT_CLEAR) begin
			need = 2 * it.expected_count;
			if (need < 16) need = 16;
			cap = 16;
			lg = MinLog2;
			while (cap < need && cap * 2 <= Depth) begin
				cap = cap * 2;
				lg++;
			end
			shadow_cap_log2 = lg[4:0];
			shadow_epoch_now = shadow_epoch_now + 32'd1;
			if (shadow_epoch_now == 32'd0) begin
				for (int i = 0; i < Depth; i++) shadow_slot_epoch[i] = '0;
				shadow_epoch_now = 32'd1;
			end
		end else if (it.action == ACT_LOOKUP || it.action == ACT_COMMIT) begin
			cap = 1 << shadow_cap_log2;
			mask = cap - 1;
			slot = int'(key_hash(it.key_top, it.key_middle, it.key_bottom) & 64'(mask));
			for (int n = 0; n < cap; n++) begin
				if (shadow_slot_epoch[slot] != shadow_epoch_now) begin
					free_slot = 1;
					break;
				end
				if (shadow_key_top[slot] == it.key_top
						&& shadow_key_middle[slot] == it.key_middle
						&& shadow_key_bottom[slot] == it.key_bottom) begin
					found = 1;
					break;
				end
				slot = (slot + 1) & mask;
			end
			if (!found && !free_slot) begin
				r.table_full = 1'b1;
			end else if (found) begin
				r.was_seen = 1'b1;
				if (it.action == ACT_COMMIT) begin
					if (it.mark_originally_delegated) shadow_orig[slot] = 1'b1;
					if (it.mark_delegation_set) shadow_set[slot] = 1'b1;
				end
				r.is_originally_delegated = shadow_orig[slot];
				r.has_delegation_set = shadow_set[slot];
			end else if (it.action == ACT_COMMIT) begin
				shadow_slot_epoch[slot] = shadow_epoch_now;
				shadow_key_top[slot] = it.key_top;
				shadow_key_middle[slot] = it.key_middle;
				shadow_key_bottom[slot] = it.key_bottom;
				shadow_orig[slot] = it.mark_originally_delegated;
				shadow_set[slot] = it.mark_delegation_set;
				r.is_originally_delegated = it.mark_originally_delegated;
				r.has_delegation_set = it.mark_delegation_set;
			end
		end
		return r;
	endfunction

	function automatic item_t make_item(logic [1:0] act, logic [159:0] key,
			logic mo, logic ms, logic [15:0] cnt);
		item_t it;
		it.action = act;
		it.key_top = key[159:128];
		it.key_middle = key[127:64];
		it.key_bottom = key[63:0];
		it.mark_originally_delegated = mo;
		it.mark_delegation_set = ms;
		it.expected_count = cnt;
		return it;
	endfunction

	function automatic logic [159:0] random_key();
		return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#400ms;
		$display("Regression FAIL");
		$finish;
	end

	// Driver: bursts of back-to-back transactions separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (start && !busy) begin
			expected_results.push_back(predict_membership(item));
			if (pending_items.size() > 0 && burst_left > 0) begin
				item <= pending_items.pop_front();
				burst_left <= burst_left - 1;
			end else begin
				start <= 1'b0;
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
			end
		end else if (!start) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_items.size() > 0) begin
				item <= pending_items.pop_front();
				start <= 1'b1;
				burst_left <= $urandom_range(0, 12);
			end
		end
	end

	// Monitor: every strobe is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				$display("%t unexpected result: expected none, actual %b", $realtime, result);
				error_count++;
			end else begin
				result_t want;
				want = expected_results.pop_front();
				if (result.was_seen !== want.was_seen) begin
					$display("%t was_seen: expected %b, actual %b", $realtime,
						want.was_seen, result.was_seen);
					error_count++;
				end
				if (result.is_originally_delegated !== want.is_originally_delegated) begin
					$display("%t is_originally_delegated: expected %b, actual %b", $realtime,
						want.is_originally_delegated, result.is_originally_delegated);
					error_count++;
				end
				if (result.has_delegation_set !== want.has_delegation_set) begin
					$display("%t has_delegation_set: expected %b, actual %b", $realtime,
						want.has_delegation_set, result.has_delegation_set);
					error_count++;
				end
				if (result.table_full !== want.table_full) begin
					$display("%t table_full: expected %b, actual %b", $realtime,
						want.table_full, result.table_full);
					error_count++;
				end
			end
		end
	end

	initial begin
		logic [159:0] k;
		int r;
		int pool_size;
		error_count = 0;
		stimulus_done = 0;
		shadow_reset();
		for (int i = 0; i < 32; i++) key_pool[i] = random_key();
		key_pool[0] = '0;
		key_pool[1] = '1;

		// Directed: extreme keys, each action, flags, full table, unknown action.
		pending_items.push_back(make_item(ACT_LOOKUP, '0, 1'b1, 1'b1, 16'hffff));
		pending_items.push_back(make_item(ACT_COMMIT, '0, 1'b0, 1'b0, '0));
		pending_items.push_back(make_item(ACT_LOOKUP, '0, 1'b0, 1'b0, '0));
		pending_items.push_back(make_item(ACT_COMMIT, '0, 1'b1, 1'b0, '0));
		pending_items.push_back(make_item(ACT_COMMIT, '0, 1'b0, 1'b1, '0));
		pending_items.push_back(make_item(ACT_COMMIT, '1, 1'b1, 1'b1, '0));
		pending_items.push_back(make_item(ACT_LOOKUP, '1, 1'b0, 1'b0, '0));
		pending_items.push_back(make_item(ACT_UNUSED, '1, 1'b1, 1'b1, 16'hffff));
		pending_items.push_back(make_item(ACT_LOOKUP, '0, 1'b0, 1'b0, '0));
		pending_items.push_back(make_item(ACT_CLEAR, '1, 1'b1, 1'b1, 16'd0));
		pending_items.push_back(make_item(ACT_LOOKUP, '0, 1'b0, 1'b0, '0));
		// Fill all 16 slots, then one more key finds the table full.
		for (int i = 0; i < 16; i++)
			pending_items.push_back(make_item(ACT_COMMIT, key_pool[i], i[0], i[1], '0));
		pending_items.push_back(make_item(ACT_COMMIT, key_pool[20], 1'b1, 1'b1, '0));
		pending_items.push_back(make_item(ACT_LOOKUP, key_pool[21], 1'b0, 1'b0, '0));
		pending_items.push_back(make_item(ACT_LOOKUP, key_pool[15], 1'b0, 1'b0, '0));
		pending_items.push_back(make_item(ACT_CLEAR, '0, 1'b0, 1'b0, 16'hffff));
		pending_items.push_back(make_item(ACT_CLEAR, '0, 1'b0, 1'b0, 16'd9));

		// Random: mostly pool keys at small capacities, with fresh keys and clears.
		pool_size = 24;
		for (int n = 0; n < 750; n++) begin
			r = $urandom_range(0, 99);
			k = ($urandom_range(0, 4) == 0) ? random_key()
				: key_pool[$urandom_range(0, pool_size - 1)];
			if (r < 4) begin
				pending_items.push_back(make_item(ACT_CLEAR, k, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)),
					($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20))));
			end else if (r < 6) begin
				pending_items.push_back(make_item(ACT_UNUSED, k, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 16'($urandom())));
			end else begin
				pending_items.push_back(make_item(r < 50 ? ACT_LOOKUP : ACT_COMMIT, k,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom())));
			end
		end

		wait (arst_n);
		wait (pending_items.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (500) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
